>>> src/dds_beep_envelope_generator_macros.svh
// ----------------------------------------------------------------------------
// DDS beep envelope generator - assertion macros
// Clocked assertion helpers; compiled out when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef DDS_BEEP_ENVELOPE_GENERATOR_MACROS_SVH
`define DDS_BEEP_ENVELOPE_GENERATOR_MACROS_SVH

`ifndef NO_ASSERTIONS
// Property must hold at every clock edge outside reset.
`define DBEG_ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("dbeg assertion failed");
// Condition must never be seen at a clock edge outside reset.
`define DBEG_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("dbeg forbidden condition seen");
`else
`define DBEG_ASSERT_CLK(label, clk, rst_n, prop)
`define DBEG_ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

>>> src/dbeg_pkg.sv
// ----------------------------------------------------------------------------
// DDS beep envelope generator - shared package
// Types, register indexes, constants and the sine table builder.
// ----------------------------------------------------------------------------
`default_nettype none

package dbeg_pkg;

    // Configuration port
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_STEP = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_STEP  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_TICKS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_TICKS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BEEP_TICKS  = 3'd5;

    localparam logic [31:0] RST_PHASE_STEP   = 32'd34359738;
    localparam logic [15:0] RST_ATTACK_STEP  = 16'd131;
    localparam logic [15:0] RST_DECAY_STEP   = 16'd131;
    localparam logic [13:0] RST_ATTACK_TICKS = 14'd250;
    localparam logic [13:0] RST_DECAY_TICKS  = 14'd250;
    localparam logic [13:0] RST_BEEP_TICKS   = 14'd10500;

    // Envelope and DAC word
    localparam int unsigned AMP_W   = 17;
    localparam int unsigned COUNT_W = 14;
    localparam int unsigned ROM_W   = 27;
    localparam logic [AMP_W-1:0] AMP_MAX       = 17'd131071;
    localparam logic [15:0]      DAC_CHAN_BITS = 16'h3000;
    localparam logic [15:0]      MID_SCALE     = 16'd2048;

    // Decoupling queue
    localparam int unsigned QUEUE_DEPTH = 4;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_ACTIVE
    } t_beep_state;

    typedef struct packed {
        logic [31:0]        phase_step;
        logic [15:0]        attack_step;
        logic [15:0]        decay_step;
        logic [COUNT_W-1:0] attack_ticks;
        logic [COUNT_W-1:0] decay_ticks;
        logic [COUNT_W-1:0] beep_ticks;
    } t_cfg;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // Q60 constants for the table build
    localparam logic [63:0] Q60_PI      = 64'h3243F6A8885A308D;
    localparam logic [63:0] Q60_HALF_PI = 64'h1921FB54442D1846;
    localparam logic [63:0] Q60_ONE_Q   = (64'd1 << 60) / 64'd1000;
    localparam logic [63:0] Q60_ONE_R   = (64'd1 << 60) % 64'd1000;
    // 6.283 in Q60
    localparam logic [63:0] K_Q60 = 64'd6283 * Q60_ONE_Q + (64'd6283 * Q60_ONE_R) / 64'd1000;

    // (a * b) >> 60, operands below 2^61
    function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[123:60];
    endfunction

    // Divide a Taylor term by (2j)(2j+1)
    function automatic logic [63:0] taylor_div(input logic [63:0] t, input int j);
        logic [63:0] r;
        unique case (j)
            1:  r = t / 64'd6;
            2:  r = t / 64'd20;
            3:  r = t / 64'd42;
            4:  r = t / 64'd72;
            5:  r = t / 64'd110;
            6:  r = t / 64'd156;
            7:  r = t / 64'd210;
            8:  r = t / 64'd272;
            9:  r = t / 64'd342;
            10: r = t / 64'd420;
            11: r = t / 64'd506;
            12: r = t / 64'd600;
            13: r = t / 64'd702;
            default: r = t / 64'd812;
        endcase
        return r;
    endfunction

    // Table entry for angle x (Q60): 2047 * sin(x) in fix15, toward zero
    function automatic logic [ROM_W-1:0] sine_entry(input logic [63:0] x_in);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        mag;
        logic signed [63:0] sum;
        logic               neg;
        x   = x_in;
        neg = 1'b0;
        if (x >= Q60_PI) begin
            x   = x - Q60_PI;
            neg = 1'b1;
        end
        if (x > Q60_HALF_PI) begin
            x = Q60_PI - x;
        end
        x2   = mul_q60(x, x);
        term = x;
        sum  = signed'(x);
        for (int j = 1; j <= 14; j++) begin
            term = taylor_div(mul_q60(term, x2), j);
            if ((j & 1) != 0) begin
                sum = sum - signed'(term);
            end else begin
                sum = sum + signed'(term);
            end
        end
        if (sum < 0) begin
            sum = '0;
        end
        mag = mul_q60(unsigned'(sum), 64'd2047 << 15);
        return neg ? ROM_W'(64'd0 - mag) : ROM_W'(mag);
    endfunction

endpackage

`default_nettype wire

>>> src/dbeg_tick_if.sv
// ----------------------------------------------------------------------------
// DDS beep envelope generator - tick channel
// One beat per sample tick, carrying the beep request flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface dbeg_tick_if;
    logic valid;
    logic ready;
    logic beep_request;

    modport source (output valid, output beep_request, input ready);
    modport sink   (input valid, input beep_request, output ready);
endinterface

`default_nettype wire

>>> src/dbeg_dac_if.sv
// ----------------------------------------------------------------------------
// DDS beep envelope generator - DAC word channel
// One beat per DAC command word.
// ----------------------------------------------------------------------------
`default_nettype none

interface dbeg_dac_if;
    logic        valid;
    logic        ready;
    logic [15:0] dac_word;

    modport source (output valid, output dac_word, input ready);
    modport sink   (input valid, input dac_word, output ready);
endinterface

`default_nettype wire

>>> src/dbeg_front.sv
// ----------------------------------------------------------------------------
// DDS beep envelope generator - front end
// Accepts ticks, runs the beep state, phase and envelope, queues sample jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module dbeg_front #(
    parameter int unsigned TABLE_DEPTH = 256
) (
    input  wire                                          i_clk,
    input  wire                                          i_rst_n,
    dbeg_tick_if.sink                                    i_tick,
    input  dbeg_pkg::t_cfg                               i_cfg,
    input  dbeg_pkg::t_q_stat                            i_q_stat,
    output logic                                         o_push,
    output logic [$clog2(TABLE_DEPTH)+dbeg_pkg::AMP_W-1:0] o_push_data
);

    localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
    localparam int unsigned AW    = dbeg_pkg::AMP_W;
    localparam int unsigned CW    = dbeg_pkg::COUNT_W;

    dbeg_pkg::t_beep_state r_state, n_state;
    logic [31:0]   r_phase, n_phase;
    logic [AW-1:0] r_amp, n_amp;
    logic [CW-1:0] r_count, n_count;

    logic          w_accept;
    logic [32+IDX_W:0] w_scaled;
    logic [AW:0]   w_att_sum;
    logic          w_decay_win;
    logic [CW-1:0] w_count_inc;
    logic          w_end;

    assign i_tick.ready = !i_q_stat.full;
    assign w_accept     = i_tick.valid && !i_q_stat.full;

    assign n_phase     = r_phase + i_cfg.phase_step;
    assign w_scaled    = {{(IDX_W+1){1'b0}}, n_phase} * (33+IDX_W)'(TABLE_DEPTH);
    assign w_att_sum   = {1'b0, r_amp} + (AW+1)'(i_cfg.attack_step);
    assign w_decay_win = ({1'b0, r_count} + {1'b0, i_cfg.decay_ticks})
                         > {1'b0, i_cfg.beep_ticks};
    assign w_count_inc = r_count + CW'(1);
    assign w_end       = (w_count_inc == i_cfg.beep_ticks);

    // Next state
    always_comb begin
        n_state = r_state;
        if (w_accept) begin
            unique case (r_state)
                dbeg_pkg::ST_IDLE: begin
                    if (i_tick.beep_request) begin
                        n_state = dbeg_pkg::ST_ACTIVE;
                    end
                end
                dbeg_pkg::ST_ACTIVE: begin
                    if (w_end) begin
                        n_state = dbeg_pkg::ST_IDLE;
                    end
                end
                default: n_state = dbeg_pkg::ST_IDLE;
            endcase
        end
    end

    // Outputs and datapath
    always_comb begin
        o_push      = 1'b0;
        o_push_data = {w_scaled[31+IDX_W:32], r_amp};
        n_amp       = r_amp;
        n_count     = r_count;
        if (w_accept) begin
            unique case (r_state)
                dbeg_pkg::ST_IDLE: begin
                    if (i_tick.beep_request) begin
                        n_amp   = '0;
                        n_count = '0;
                    end
                end
                dbeg_pkg::ST_ACTIVE: begin
                    o_push = 1'b1;
                    if (r_count < i_cfg.attack_ticks) begin
                        n_amp = w_att_sum[AW] ? dbeg_pkg::AMP_MAX : w_att_sum[AW-1:0];
                    end else if (w_decay_win) begin
                        n_amp = (r_amp > AW'(i_cfg.decay_step))
                              ? r_amp - AW'(i_cfg.decay_step) : '0;
                    end
                    n_count = w_count_inc;
                    if (w_end) begin
                        n_amp   = '0;
                        n_count = '0;
                    end
                end
                default: begin
                    n_amp   = '0;
                    n_count = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dbeg_pkg::ST_IDLE;
            r_phase <= '0;
            r_amp   <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_amp   <= n_amp;
            r_count <= n_count;
            if (o_push) begin
                r_phase <= n_phase;
            end
        end
    end

endmodule

`default_nettype wire

>>> src/dbeg_queue.sv
// ----------------------------------------------------------------------------
// DDS beep envelope generator - job queue
// Short FIFO between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module dbeg_queue #(
    parameter int unsigned WIDTH = 25
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_push,
    input  wire  [WIDTH-1:0]         i_push_data,
    input  wire                      i_pop,
    output logic [WIDTH-1:0]         o_head,
    output dbeg_pkg::t_q_stat        o_stat
);

    localparam int unsigned DEPTH = dbeg_pkg::QUEUE_DEPTH;
    localparam int unsigned PTR_W = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [PTR_W:0]   r_count;

    assign o_head       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == (PTR_W+1)'(DEPTH));
    assign o_stat.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            priority if (i_push && !i_pop) begin
                r_count <= r_count + (PTR_W+1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (PTR_W+1)'(1);
            end
        end
    end

endmodule

`default_nettype wire

>>> src/dbeg_sine_rom.sv
// ----------------------------------------------------------------------------
// DDS beep envelope generator - sine table
// Constant fix15 sine table, built at elaboration, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module dbeg_sine_rom #(
    parameter int unsigned TABLE_DEPTH = 256
) (
    input  wire                                     i_clk,
    input  wire                                     i_en,
    input  wire  [$clog2(TABLE_DEPTH)-1:0]          i_addr,
    output logic signed [dbeg_pkg::ROM_W-1:0]       o_data
);

    localparam logic [63:0] KQ = dbeg_pkg::K_Q60 / TABLE_DEPTH;
    localparam logic [63:0] KR = dbeg_pkg::K_Q60 % TABLE_DEPTH;

    logic [dbeg_pkg::ROM_W-1:0] w_tab [TABLE_DEPTH];

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_entry
        localparam logic [63:0] ANGLE = KQ * 64'(g) + (KR * 64'(g)) / TABLE_DEPTH;
        assign w_tab[g] = dbeg_pkg::sine_entry(ANGLE);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_data <= signed'(w_tab[i_addr]);
        end
    end

endmodule

`default_nettype wire

>>> src/dbeg_back.sv
// ----------------------------------------------------------------------------
// DDS beep envelope generator - back end
// Table read, envelope multiply, DAC word forming and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dbeg_back #(
    parameter int unsigned TABLE_DEPTH = 256
) (
    input  wire                                            i_clk,
    input  wire                                            i_rst_n,
    input  wire  [$clog2(TABLE_DEPTH)+dbeg_pkg::AMP_W-1:0] i_q_head,
    input  dbeg_pkg::t_q_stat                              i_q_stat,
    output logic                                           o_pop,
    dbeg_dac_if.source                                     o_dac
);

    localparam int unsigned IDX_W  = $clog2(TABLE_DEPTH);
    localparam int unsigned AW     = dbeg_pkg::AMP_W;
    localparam int unsigned RW     = dbeg_pkg::ROM_W;
    localparam int unsigned PROD_W = AW + 1 + RW;

    logic                     w_adv;
    logic signed [RW-1:0]     w_rom_data;
    logic signed [15:0]       w_sample;
    logic [15:0]              w_word;

    logic                     r_s1_valid;
    logic [AW-1:0]            r_s1_amp;
    logic                     r_s2_valid;
    logic signed [PROD_W-1:0] r_s2_prod;
    logic                     r_out_valid;
    logic [15:0]              r_out_word;

    // Advance the whole pipe whenever the output register frees up
    assign w_adv = !r_out_valid || o_dac.ready;
    assign o_pop = w_adv && !i_q_stat.empty;

    dbeg_sine_rom #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_rom (
        .i_clk  (i_clk),
        .i_en   (o_pop),
        .i_addr (i_q_head[IDX_W+AW-1:AW]),
        .o_data (w_rom_data)
    );

    // Floor shift by 30, offset to mid scale, tag channel bits
    assign w_sample = 16'(signed'(r_s2_prod[PROD_W-1:30]));
    assign w_word   = (w_sample + dbeg_pkg::MID_SCALE) | dbeg_pkg::DAC_CHAN_BITS;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_amp <= i_q_head[AW-1:0];
        end
        if (w_adv) begin
            r_s2_prod  <= signed'({1'b0, r_s1_amp}) * w_rom_data;
            r_out_word <= w_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid  <= o_pop;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid;
        end
    end

    assign o_dac.valid    = r_out_valid;
    assign o_dac.dac_word = r_out_word;

endmodule

`default_nettype wire

>>> src/dds_beep_envelope_generator.sv
// A tick's job goes through the job queue, table read, product and output registers.
// Throughput: one tick per cycle while the queue has room; idle ticks give no word.
// The front end takes a tick each cycle while the four-entry job queue has room.
// Reset: i_rst_n synchronous, active low; clears beep state, phase, envelope, queue,
// pipe valids and loads the register defaults. The sine table is constant.
// ----------------------------------------------------------------------------
// DDS beep envelope generator - top level
// DDS sine tone with linear attack/decay envelope, one DAC word per active tick.
// ----------------------------------------------------------------------------
`default_nettype none
`include "dds_beep_envelope_generator_macros.svh"

module dds_beep_envelope_generator #(
    parameter int unsigned TABLE_DEPTH = 256
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    dbeg_tick_if.sink                          i_tick,
    dbeg_dac_if.source                         o_dac,
    input  wire                                i_cfg_we,
    input  wire  [dbeg_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire  [dbeg_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int unsigned QW = $clog2(TABLE_DEPTH) + dbeg_pkg::AMP_W;

    dbeg_pkg::t_cfg    r_cfg;
    dbeg_pkg::t_q_stat w_q_stat;
    logic              w_push;
    logic [QW-1:0]     w_push_data;
    logic              w_pop;
    logic [QW-1:0]     w_q_head;

    // Register file: a write lands at its edge and takes effect on the next tick;
    // write only while nothing is in flight. Unknown indexes drop silently.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.phase_step   <= dbeg_pkg::RST_PHASE_STEP;
            r_cfg.attack_step  <= dbeg_pkg::RST_ATTACK_STEP;
            r_cfg.decay_step   <= dbeg_pkg::RST_DECAY_STEP;
            r_cfg.attack_ticks <= dbeg_pkg::RST_ATTACK_TICKS;
            r_cfg.decay_ticks  <= dbeg_pkg::RST_DECAY_TICKS;
            r_cfg.beep_ticks   <= dbeg_pkg::RST_BEEP_TICKS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                dbeg_pkg::CFG_PHASE_STEP:   r_cfg.phase_step   <= i_cfg_data;
                dbeg_pkg::CFG_ATTACK_STEP:  r_cfg.attack_step  <= i_cfg_data[15:0];
                dbeg_pkg::CFG_DECAY_STEP:   r_cfg.decay_step   <= i_cfg_data[15:0];
                dbeg_pkg::CFG_ATTACK_TICKS: r_cfg.attack_ticks <= i_cfg_data[13:0];
                dbeg_pkg::CFG_DECAY_TICKS:  r_cfg.decay_ticks  <= i_cfg_data[13:0];
                dbeg_pkg::CFG_BEEP_TICKS:   r_cfg.beep_ticks   <= i_cfg_data[13:0];
                default: ;
            endcase
        end
    end

    // Front: classify ticks, step phase and envelope, push one job per active tick
    dbeg_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tick      (i_tick),
        .i_cfg       (r_cfg),
        .i_q_stat    (w_q_stat),
        .o_push      (w_push),
        .o_push_data (w_push_data)
    );

    // Queue: hold {table index, amplitude} jobs so each side can stall alone
    dbeg_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .i_pop       (w_pop),
        .o_head      (w_q_head),
        .o_stat      (w_q_stat)
    );

    // Back: table read, scale by envelope, form the DAC word, hold for the sink
    dbeg_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_head (w_q_head),
        .i_q_stat (w_q_stat),
        .o_pop    (w_pop),
        .o_dac    (o_dac)
    );

    // Never push into a full queue nor pop an empty one
    `DBEG_ASSERT_NEVER(a_push_full, i_clk, i_rst_n, w_push && w_q_stat.full)
    `DBEG_ASSERT_NEVER(a_pop_empty, i_clk, i_rst_n, w_pop && w_q_stat.empty)
    // A job only comes from an accepted tick
    `DBEG_ASSERT_CLK(a_push_on_beat, i_clk, i_rst_n, w_push |-> (i_tick.valid && i_tick.ready))
    // Every DAC beat carries the channel bits
    `DBEG_ASSERT_CLK(a_chan_bits, i_clk, i_rst_n, o_dac.valid |-> (o_dac.dac_word[13:12] == 2'b11))

endmodule

`default_nettype wire
